// ----- hdl/pse_pkg.sv -----
// Shared types and constants for the PLL setting encoder.
package pse_pkg;

  // LFSR seeds and range limits
  localparam logic [14:0] MDEC_SEED  = 15'h4000;
  localparam logic [7:0]  NDEC_SEED  = 8'h80;
  localparam logic [4:0]  PDEC_SEED  = 5'h10;
  localparam logic [16:0] MSEL_LIMIT = 17'd32768;
  localparam logic [13:0] NSEL_LIMIT = 14'd256;

  // Fixed words for selects 1 and 2
  localparam logic [16:0] MDEC_SEL1 = 17'h18003;
  localparam logic [16:0] MDEC_SEL2 = 17'h10003;
  localparam logic [9:0]  NDEC_SEL1 = 10'h302;
  localparam logic [9:0]  NDEC_SEL2 = 10'h202;
  localparam logic [6:0]  PDEC_SEL1 = 7'h62;
  localparam logic [6:0]  PDEC_SEL2 = 7'h42;

  // Bandwidth divide numerator
  localparam logic [10:0] BW_NUMER = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MSEL_ZERO = 2'd1,
    ST_DIV_ZERO  = 2'd2,
    ST_NSEL_HIGH = 2'd3
  } pse_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } pse_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic publish;
  } pse_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic busy;
  } pse_sts_t;

endpackage

// ----- hdl/pse_datapath.sv -----
// Datapath: divisor split, three coding LFSRs, bandwidth divider, output register.
module pse_datapath import pse_pkg::*; (
  input  logic        clk,
  input  pse_cmd_t    cmd,
  output pse_sts_t    sts,
  input  logic [16:0] in_multiplier,
  input  logic [13:0] in_divisor,
  output logic [16:0] out_mdec,
  output logic [9:0]  out_ndec,
  output logic [6:0]  out_pdec,
  output logic [5:0]  out_seli,
  output logic [4:0]  out_selp,
  output logic        out_direct_in,
  output logic        out_direct_out,
  output logic [1:0]  out_status
);

  // load-time decode
  logic [2:0]  tz;
  logic [15:0] msel_in;
  logic [13:0] nsel_in;
  logic [4:0]  post_in;
  logic [15:0] steps_m;
  logic [8:0]  steps_n;
  logic [5:0]  steps_p;
  pse_status_t st_in;

  // working registers
  logic [15:0] msel_r;
  logic [13:0] nsel_r;
  logic [4:0]  post_r;
  logic        din_r, dout_r;
  pse_status_t st_r;
  logic [14:0] mlfsr_r;
  logic [7:0]  nlfsr_r;
  logic [4:0]  plfsr_r;
  logic [15:0] cnt_m_r;
  logic [8:0]  cnt_n_r;
  logic [5:0]  cnt_p_r;
  logic [16:0] dvs_r;
  logic [10:0] rem_r;
  logic [6:0]  quo_r;
  logic        div_done;

  // output register
  logic [16:0] mdec_r, mdec_nxt;
  logic [9:0]  ndec_r, ndec_nxt;
  logic [6:0]  pdec_r, pdec_nxt;
  logic [5:0]  seli_r, seli_nxt;
  logic [4:0]  selp_r, selp_nxt;
  logic        din_o_r, dout_o_r;
  logic [1:0]  st_o_r;

  always_comb begin
    priority if (in_divisor[0]) tz = 3'd0;
    else if (in_divisor[1])     tz = 3'd1;
    else if (in_divisor[2])     tz = 3'd2;
    else if (in_divisor[3])     tz = 3'd3;
    else if (in_divisor[4])     tz = 3'd4;
    else                        tz = 3'd5;
    msel_in = in_multiplier[16:1];
    nsel_in = in_divisor >> tz;
    post_in = (tz == 3'd0) ? 5'd1 : (5'd1 << (tz - 3'd1));
    if (msel_in >= 16'd3 && {1'b0, msel_in} <= MSEL_LIMIT)
      steps_m = 16'(17'(MSEL_LIMIT + 17'd1) - {1'b0, msel_in});
    else
      steps_m = '0;
    if (nsel_in >= 14'd3 && nsel_in <= NSEL_LIMIT)
      steps_n = 9'(14'(NSEL_LIMIT + 14'd1) - nsel_in);
    else
      steps_n = '0;
    if (post_in >= 5'd3)
      steps_p = 6'd33 - {1'b0, post_in};
    else
      steps_p = '0;
    priority if (msel_in == '0)         st_in = ST_MSEL_ZERO;
    else if (in_divisor == '0)          st_in = ST_DIV_ZERO;
    else if (nsel_in > NSEL_LIMIT)      st_in = ST_NSEL_HIGH;
    else                                st_in = ST_OK;
  end

  assign div_done = ({6'd0, rem_r} < dvs_r);
  assign sts.busy = (cnt_m_r != '0) || (cnt_n_r != '0) || (cnt_p_r != '0) || !div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msel_r  <= msel_in;
      nsel_r  <= nsel_in;
      post_r  <= post_in;
      din_r   <= (nsel_in == 14'd1);
      dout_r  <= (tz == 3'd0);
      st_r    <= st_in;
      mlfsr_r <= MDEC_SEED;
      nlfsr_r <= NDEC_SEED;
      plfsr_r <= PDEC_SEED;
      cnt_m_r <= steps_m;
      cnt_n_r <= steps_n;
      cnt_p_r <= steps_p;
      dvs_r   <= {1'b0, msel_in} + 17'd9;
      rem_r   <= BW_NUMER;
      quo_r   <= '0;
    end else begin
      if (cnt_m_r != '0) begin
        mlfsr_r <= {mlfsr_r[0] ^ mlfsr_r[1], mlfsr_r[14:1]};
        cnt_m_r <= cnt_m_r - 16'd1;
      end
      if (cnt_n_r != '0) begin
        nlfsr_r <= {nlfsr_r[0] ^ nlfsr_r[2] ^ nlfsr_r[3] ^ nlfsr_r[4], nlfsr_r[7:1]};
        cnt_n_r <= cnt_n_r - 9'd1;
      end
      if (cnt_p_r != '0) begin
        plfsr_r <= {plfsr_r[0] ^ plfsr_r[2], plfsr_r[4:1]};
        cnt_p_r <= cnt_p_r - 6'd1;
      end
      // divide by repeated subtraction, one step a cycle
      if (!div_done) begin
        rem_r <= rem_r - dvs_r[10:0];
        quo_r <= quo_r + 7'd1;
      end
    end
  end

  always_comb begin
    unique case (msel_r)
      16'd0:   mdec_nxt = '0;
      16'd1:   mdec_nxt = MDEC_SEL1;
      16'd2:   mdec_nxt = MDEC_SEL2;
      default: mdec_nxt = {2'b00, mlfsr_r};
    endcase
    unique case (nsel_r)
      14'd0:   ndec_nxt = '0;
      14'd1:   ndec_nxt = NDEC_SEL1;
      14'd2:   ndec_nxt = NDEC_SEL2;
      default: ndec_nxt = {2'b00, nlfsr_r};
    endcase
    unique case (post_r)
      5'd1:    pdec_nxt = PDEC_SEL1;
      5'd2:    pdec_nxt = PDEC_SEL2;
      default: pdec_nxt = {2'b00, plfsr_r};
    endcase
    priority if (msel_r > 16'd16384) seli_nxt = 6'd1;
    else if (msel_r > 16'd8192)      seli_nxt = 6'd2;
    else if (msel_r > 16'd2048)      seli_nxt = 6'd4;
    else if (msel_r >= 16'd501)      seli_nxt = 6'd8;
    else if (msel_r >= 16'd60)       seli_nxt = {quo_r[3:0], 2'b00};
    else                             seli_nxt = {msel_r[5:2], 2'b00} + 6'd4;
    selp_nxt = (msel_r < 16'd60) ? (msel_r[5:1] + 5'd1) : 5'd31;
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      mdec_r   <= mdec_nxt;
      ndec_r   <= ndec_nxt;
      pdec_r   <= pdec_nxt;
      seli_r   <= seli_nxt;
      selp_r   <= selp_nxt;
      din_o_r  <= din_r;
      dout_o_r <= dout_r;
      st_o_r   <= st_r;
    end
  end

  assign out_mdec       = mdec_r;
  assign out_ndec       = ndec_r;
  assign out_pdec       = pdec_r;
  assign out_seli       = seli_r;
  assign out_selp       = selp_r;
  assign out_direct_in  = din_o_r;
  assign out_direct_out = dout_o_r;
  assign out_status     = st_o_r;

endmodule

// ----- hdl/pse_ctrl.sv -----
// Controller: sequences load, LFSR run and hand-off to the output register.
module pse_ctrl import pse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  pse_sts_t sts,
  output pse_cmd_t cmd
);

  pse_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.publish = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.busy) begin
          if (slot_free) begin
            cmd.publish = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.publish)     out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/pll_setting_encoder_unit.sv -----
// Top level of the PLL setting encoder: controller, datapath and checks.
// Each item (multiplier, divisor) yields one result item with the coded MDEC,
// NDEC and PDEC words, the SELI/SELP bandwidth values, the direct input/output
// flags and a status code (0 ok, 1 multiplier select zero, 2 zero divisor,
// 3 pre-divider select above 256). One item is worked on at a time. The work
// on an item lasts as long as the longest of: the MDEC LFSR steps (32769 -
// multiplier/2 for selects 3 to 32768, else none), the NDEC steps (257 -
// pre-divider select for 3 to 256), the PDEC steps (at most 29) and the
// bandwidth divide steps (1024 / (select + 9), at most 113). The MDEC LFSR,
// stepped once a cycle, sets the worst case at multiplier select 3. The
// finished result sits in an output register, so the next item is taken while
// it waits to be read; only a second finished result waits for the register
// to empty.
module pll_setting_encoder_unit import pse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] in_multiplier,
  input  logic [13:0] in_divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_mdec,
  output logic [9:0]  out_ndec,
  output logic [6:0]  out_pdec,
  output logic [5:0]  out_seli,
  output logic [4:0]  out_selp,
  output logic        out_direct_in,
  output logic        out_direct_out,
  output logic [1:0]  out_status
);

  pse_cmd_t cmd;   // load a new item, move the result to the output register
  pse_sts_t sts;   // LFSRs or divider still stepping

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pse_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_multiplier  (in_multiplier),
    .in_divisor     (in_divisor),
    .out_mdec       (out_mdec),
    .out_ndec       (out_ndec),
    .out_pdec       (out_pdec),
    .out_seli       (out_seli),
    .out_selp       (out_selp),
    .out_direct_in  (out_direct_in),
    .out_direct_out (out_direct_out),
    .out_status     (out_status)
  );

  // An accepted item always stalls the input in the cycle after its acceptance
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after item load");

  // Loading and publishing never coincide
  a_load_vs_publish: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.publish))
    else $error("load and publish in the same cycle");

  // A published result shows up as a valid item next cycle
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid)
    else $error("published result not valid");

  // Multiplier select zero always codes to an all-zero MDEC word
  a_msel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MSEL_ZERO) |-> (out_mdec == '0))
    else $error("mdec nonzero for multiplier select zero");

endmodule
